/* hw/rtl/nearest_neighbor_thumbnail_scaler_defines.svh */
// Assertion macros for the checker file of the thumbnail scaler.
`ifndef NEAREST_NEIGHBOR_THUMBNAIL_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_THUMBNAIL_SCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nnts: same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NNTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnts: next-cycle assertion failed");

`endif

/* hw/rtl/nnts_pkg.sv */
package nnts_pkg;

    localparam int DIM_W     = 13;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int INC_W     = DIM_W + 1;
    localparam int CNT_W     = $clog2(PROD_W + 1);
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int CFG_IDX_W = 2;

    typedef logic [DIM_W-1:0] t_dim;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SOURCE_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SOURCE_HEIGHT = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_TARGET_SIZE   = t_cfg_idx'(2);

    localparam t_dim SOURCE_RESET = t_dim'(1);
    localparam t_dim TARGET_RESET = t_dim'(64);

endpackage

/* hw/rtl/nearest_neighbor_thumbnail_scaler.sv */
// A kept pixel's result is registered in S_EVAL after its beat is taken; for the first pixel of
// a frame, S_SETUP (the multiply) and 26 divider steps in S_DIV come first.
// No new pixel is taken until the last is through; one that advances the next column or row target
// (a kept pixel before its row's end, or the last pixel of a hit row before the last row) also
// waits for 14 steps of the shared divider. A stalled result stalls only the next kept pixel.
// Reset (synchronous, active low) restores the register defaults and restarts the frame.
module nearest_neighbor_thumbnail_scaler
    import nnts_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_word,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CH_W-1:0]  o_red,
    output logic [CH_W-1:0]  o_green,
    output logic [CH_W-1:0]  o_blue,
    output logic [CH_W-1:0]  o_alpha,
    output logic [DIM_W-1:0] o_thumb_width,
    output logic [DIM_W-1:0] o_thumb_height,
    output logic             o_frame_last
);

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_EVAL, S_DIV} t_state;
    typedef enum logic [1:0] {DIV_DIM, DIV_COL, DIV_ROW} t_div_use;

    function automatic t_dim clamp_dim(input t_dim v);
        t_dim r;
        if (v == '0) begin
            r = t_dim'(1);
        end else if (32'(v) > MAX_DIMENSION) begin
            r = t_dim'(MAX_DIMENSION);
        end else begin
            r = v;
        end
        return r;
    endfunction

    t_state           r_state;
    t_div_use         r_div_use;
    t_dim             r_sw, r_sh, r_tsz;
    logic [PIX_W-1:0] r_pix;
    t_dim             r_col_pos, r_row_pos, r_out_col, r_out_row;
    t_dim             r_col_tgt, r_col_rem, r_row_tgt, r_row_rem;
    t_dim             r_cw, r_ch;
    logic             r_wide;
    t_dim             r_div_rem, r_div_den;
    logic [PROD_W-1:0] r_div_quo;
    logic [CNT_W-1:0] r_div_cnt;
    logic             r_o_valid, r_o_last;
    logic [PIX_W-1:0] r_o_pix;
    t_dim             r_o_tw, r_o_th;

    t_dim              sw_c, sh_c, longer, shorter, t_sat;
    logic              wide;
    logic [PROD_W-1:0] setup_prod;
    logic              row_hit, emit, out_free, col_wrap, row_wrap, need_col, need_row;
    t_dim              out_col_inc, out_row_inc, col_pos_inc, row_pos_inc;
    logic [INC_W-1:0]  div_shift, div_diff, col_dvd, row_dvd;
    logic              div_ge;
    t_dim              div_rem_nx;
    logic [PROD_W-1:0] div_quo_nx;

    always_comb begin
        sw_c    = clamp_dim(r_sw);
        sh_c    = clamp_dim(r_sh);
        wide    = sw_c > sh_c;
        longer  = wide ? sw_c : sh_c;
        shorter = wide ? sh_c : sw_c;
        t_sat   = (r_tsz > longer) ? longer : r_tsz;
    end

    assign setup_prod = PROD_W'(shorter) * PROD_W'(t_sat);

    always_comb begin
        row_hit = (r_cw != '0) && (r_ch != '0) && (r_out_row < r_ch) &&
                  (r_row_pos == r_row_tgt);
        emit    = row_hit && (r_out_col < r_cw) && (r_col_pos == r_col_tgt);
        out_col_inc = r_out_col + t_dim'(1);
        out_row_inc = r_out_row + t_dim'(1);
        col_pos_inc = r_col_pos + t_dim'(1);
        row_pos_inc = r_row_pos + t_dim'(1);
        col_wrap = col_pos_inc >= sw_c;
        row_wrap = row_pos_inc >= sh_c;
        out_free = !r_o_valid || !i_stall;
        // A row change clears the column targets, so at most one division follows.
        need_col = emit && (out_col_inc < r_cw) && !(col_wrap && row_hit);
        need_row = col_wrap && row_hit && (out_row_inc < r_ch);
        col_dvd  = {1'b0, r_col_rem} + {1'b0, sw_c};
        row_dvd  = {1'b0, r_row_rem} + {1'b0, sh_c};
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb begin
        div_shift  = {r_div_rem, r_div_quo[PROD_W-1]};
        div_ge     = div_shift >= {1'b0, r_div_den};
        div_diff   = div_shift - {1'b0, r_div_den};
        div_rem_nx = div_ge ? div_diff[DIM_W-1:0] : div_shift[DIM_W-1:0];
        div_quo_nx = {r_div_quo[PROD_W-2:0], div_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_use <= DIV_DIM;
            r_sw      <= SOURCE_RESET;
            r_sh      <= SOURCE_RESET;
            r_tsz     <= TARGET_RESET;
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_col_tgt <= '0;
            r_col_rem <= '0;
            r_row_tgt <= '0;
            r_row_rem <= '0;
            r_cw      <= '0;
            r_ch      <= '0;
            r_wide    <= 1'b0;
            r_div_cnt <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid && !i_cfg_we) begin
                        r_pix   <= i_pixel_word;
                        r_state <= (r_col_pos == '0 && r_row_pos == '0) ? S_SETUP : S_EVAL;
                    end
                end
                S_SETUP: begin
                    r_wide <= wide;
                    if (wide) begin
                        r_cw <= t_sat;
                    end else begin
                        r_ch <= t_sat;
                    end
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_col_tgt <= '0;
                    r_col_rem <= '0;
                    r_row_tgt <= '0;
                    r_row_rem <= '0;
                    r_div_quo <= setup_prod;
                    r_div_rem <= '0;
                    r_div_den <= longer;
                    r_div_cnt <= CNT_W'(PROD_W);
                    r_div_use <= DIV_DIM;
                    r_state   <= S_DIV;
                end
                S_EVAL: begin
                    if (!emit || out_free) begin
                        if (emit) begin
                            r_o_valid <= 1'b1;
                            r_o_pix   <= r_pix;
                            r_o_tw    <= r_cw;
                            r_o_th    <= r_ch;
                            r_o_last  <= (out_col_inc == r_cw) && (out_row_inc == r_ch);
                            r_out_col <= out_col_inc;
                        end
                        if (col_wrap) begin
                            r_col_pos <= '0;
                            r_row_pos <= row_wrap ? t_dim'(0) : row_pos_inc;
                            if (row_hit) begin
                                r_out_row <= out_row_inc;
                                r_out_col <= '0;
                                r_col_tgt <= '0;
                                r_col_rem <= '0;
                            end
                        end else begin
                            r_col_pos <= col_pos_inc;
                        end
                        // The quotient and remainder advance by one step of sw (or sh).
                        if (need_col) begin
                            r_div_quo <= {col_dvd, (PROD_W - INC_W)'(0)};
                            r_div_rem <= '0;
                            r_div_den <= r_cw;
                            r_div_cnt <= CNT_W'(INC_W);
                            r_div_use <= DIV_COL;
                            r_state   <= S_DIV;
                        end else if (need_row) begin
                            r_div_quo <= {row_dvd, (PROD_W - INC_W)'(0)};
                            r_div_rem <= '0;
                            r_div_den <= r_ch;
                            r_div_cnt <= CNT_W'(INC_W);
                            r_div_use <= DIV_ROW;
                            r_state   <= S_DIV;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_div_rem <= div_rem_nx;
                    r_div_quo <= div_quo_nx;
                    r_div_cnt <= r_div_cnt - CNT_W'(1);
                    if (r_div_cnt == CNT_W'(1)) begin
                        case (r_div_use)
                            DIV_DIM: begin
                                if (r_wide) begin
                                    r_ch <= t_dim'(div_quo_nx);
                                end else begin
                                    r_cw <= t_dim'(div_quo_nx);
                                end
                                r_state <= S_EVAL;
                            end
                            DIV_COL: begin
                                r_col_tgt <= r_col_tgt + t_dim'(div_quo_nx);
                                r_col_rem <= div_rem_nx;
                                r_state   <= S_IDLE;
                            end
                            DIV_ROW: begin
                                r_row_tgt <= r_row_tgt + t_dim'(div_quo_nx);
                                r_row_rem <= div_rem_nx;
                                r_state   <= S_IDLE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A register write restarts the frame; the next pixel starts a new one.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SOURCE_WIDTH:  r_sw  <= i_cfg_data;
                    CFG_SOURCE_HEIGHT: r_sh  <= i_cfg_data;
                    CFG_TARGET_SIZE:   r_tsz <= i_cfg_data;
                    default: begin
                    end
                endcase
                r_col_pos <= '0;
                r_row_pos <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_col_tgt <= '0;
                r_col_rem <= '0;
                r_row_tgt <= '0;
                r_row_rem <= '0;
                r_state   <= S_IDLE;
            end
        end
    end

    assign o_stall        = (r_state != S_IDLE) || i_cfg_we;
    assign o_valid        = r_o_valid;
    assign o_red          = r_o_pix[31:24];
    assign o_green        = r_o_pix[23:16];
    assign o_blue         = r_o_pix[15:8];
    assign o_alpha        = r_o_pix[7:0];
    assign o_thumb_width  = r_o_tw;
    assign o_thumb_height = r_o_th;
    assign o_frame_last   = r_o_last;

endmodule

/* hw/rtl/nnts_checker.sv */
`include "nearest_neighbor_thumbnail_scaler_defines.svh"

module nnts_checker
    import nnts_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [DIM_W-1:0] o_thumb_width,
    input logic [DIM_W-1:0] o_thumb_height
);

    // A result beat holds until it is taken.
    `NNTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    // Only frames with a nonzero thumbnail produce beats.
    `NNTS_ASSERT_IMP(a_thumb_nonzero, i_clk, i_rst_n, o_valid, (o_thumb_width != '0) && (o_thumb_height != '0))
    // Every accepted pixel is evaluated before the next one is taken.
    `NNTS_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_valid && !o_stall && !i_cfg_we, o_stall)
    // A new result appears only out of work on an accepted pixel.
    `NNTS_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

endmodule

bind nearest_neighbor_thumbnail_scaler nnts_checker u_nnts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_thumb_width  (o_thumb_width),
    .o_thumb_height (o_thumb_height)
);

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnts_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 900;
    localparam int LIMIT_NS      = 1_600_000;

    localparam t_cfg_idx CFG_SPARE_INDEX = t_cfg_idx'(3);

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        t_dim            thumb_w;
        t_dim            thumb_h;
        logic            last;
    } thumb_pixel_t;

    // Tracks the scaler's frame walk and holds the thumbnail pixels still to come.
    class thumb_scoreboard;
        t_dim src_w, src_h, target;
        t_dim col_pos, row_pos;
        t_dim out_col, out_row;
        t_dim col_target, row_target;
        t_dim thumb_w, thumb_h;
        thumb_pixel_t expected_pixels[$];
        int mismatches;
        int checked;
        int frames_done;

        function new();
            src_w       = SOURCE_RESET;
            src_h       = SOURCE_RESET;
            target      = TARGET_RESET;
            thumb_w     = '0;
            thumb_h     = '0;
            mismatches  = 0;
            checked     = 0;
            frames_done = 0;
            restart();
        endfunction

        static function t_dim clamp_dim(t_dim v);
            if (v == 0) return t_dim'(1);
            if (v > MAX_DIM) return t_dim'(MAX_DIM);
            return v;
        endfunction

        function void restart();
            col_pos    = '0;
            row_pos    = '0;
            out_col    = '0;
            out_row    = '0;
            col_target = '0;
            row_target = '0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void write_register(t_cfg_idx idx, t_dim val);
            case (idx)
                CFG_SOURCE_WIDTH:  src_w = val;
                CFG_SOURCE_HEIGHT: src_h = val;
                CFG_TARGET_SIZE:   target = val;
                default: ;
            endcase
            // Any write, even to the spare index, drops the frame in progress.
            restart();
        endfunction

        function void note_pixel(logic [PIX_W-1:0] word);
            t_dim sw, sh, t, longer;
            logic [PROD_W-1:0] prod;
            logic row_hit;
            thumb_pixel_t px;
            sw = clamp_dim(src_w);
            sh = clamp_dim(src_h);
            if (col_pos == 0 && row_pos == 0) begin
                t = target;
                longer = (sw > sh) ? sw : sh;
                if (t > longer) t = longer;
                if (sw > sh) begin
                    thumb_w = t;
                    prod = sh * t;
                    thumb_h = t_dim'(prod / sw);
                end else begin
                    thumb_h = t;
                    prod = sw * t;
                    thumb_w = t_dim'(prod / sh);
                end
                restart();
            end
            row_hit = thumb_w != 0 && thumb_h != 0 && out_row < thumb_h &&
                      row_pos == row_target;
            if (row_hit && out_col < thumb_w && col_pos == col_target) begin
                px.red     = word[31:24];
                px.green   = word[23:16];
                px.blue    = word[15:8];
                px.alpha   = word[7:0];
                px.thumb_w = thumb_w;
                px.thumb_h = thumb_h;
                px.last    = (out_col + 1 == thumb_w) && (out_row + 1 == thumb_h);
                expected_pixels.push_back(px);
                out_col++;
                if (out_col < thumb_w) begin
                    prod = out_col * sw;
                    col_target = t_dim'(prod / thumb_w);
                end
            end
            col_pos++;
            if (col_pos >= sw) begin
                col_pos = '0;
                if (row_hit) begin
                    out_row++;
                    out_col = '0;
                    col_target = '0;
                    if (out_row < thumb_h) begin
                        prod = out_row * sh;
                        row_target = t_dim'(prod / thumb_h);
                    end
                end
                row_pos++;
                if (row_pos >= sh) row_pos = '0;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                          checked, name, got, want));
        endtask

        task check_result(thumb_pixel_t got);
            thumb_pixel_t want;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected (rgba %h%h%h%h)",
                                          got.red, got.green, got.blue, got.alpha));
            end else begin
                want = expected_pixels.pop_front();
                compare_field("red", got.red, want.red);
                compare_field("green", got.green, want.green);
                compare_field("blue", got.blue, want.blue);
                compare_field("alpha", got.alpha, want.alpha);
                compare_field("thumb_width", got.thumb_w, want.thumb_w);
                compare_field("thumb_height", got.thumb_h, want.thumb_h);
                compare_field("frame_last", got.last, want.last);
                if (want.last) frames_done++;
                checked++;
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_index;
    logic [DIM_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel_word;
    logic             o_valid;
    logic             i_stall;
    logic [CH_W-1:0]  o_red;
    logic [CH_W-1:0]  o_green;
    logic [CH_W-1:0]  o_blue;
    logic [CH_W-1:0]  o_alpha;
    logic [DIM_W-1:0] o_thumb_width;
    logic [DIM_W-1:0] o_thumb_height;
    logic             o_frame_last;

    thumb_scoreboard sb = new();
    bit quiet_phase = 1'b0;
    int beats_in = 0;
    int phases = 0;

    t_cfg_idx reg_order [3] = '{CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT, CFG_TARGET_SIZE};

    nearest_neighbor_thumbnail_scaler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_word   (i_pixel_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_thumb_width  (o_thumb_width),
        .o_thumb_height (o_thumb_height),
        .o_frame_last   (o_frame_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        thumb_pixel_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.red     = o_red;
            got.green   = o_green;
            got.blue    = o_blue;
            got.alpha   = o_alpha;
            got.thumb_w = o_thumb_width;
            got.thumb_h = o_thumb_height;
            got.last    = o_frame_last;
            sb.check_result(got);
        end
    end

    // Receiver: after each accepted result beat, hold off for a random number of cycles.
    initial begin
        int hold;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                hold = quiet_phase ? 0 : $urandom_range(0, 7);
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout: the scaler stopped making progress");
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] word);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_word <= word;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(word);
        beats_in++;
    endtask

    // Lowers valid, waits for every expected result, then lets the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_dim sw, input t_dim sh, input t_dim ts,
                                  input bit spare);
        int first;
        int n;
        t_cfg_idx idx;
        t_dim val;
        first = $urandom_range(0, 2);
        n = spare ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            if (k == 3) begin
                idx = CFG_SPARE_INDEX;
                val = t_dim'($urandom);
            end else begin
                idx = reg_order[(first + k) % 3];
                case (idx)
                    CFG_SOURCE_WIDTH:  val = sw;
                    CFG_SOURCE_HEIGHT: val = sh;
                    default:           val = ts;
                endcase
            end
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
            sb.write_register(idx, val);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input t_dim sw, input t_dim sh, input t_dim ts,
                             input bit spare, input int npix);
        logic [PIX_W-1:0] word;
        apply_settings(sw, sh, ts, spare);
        quiet_phase = ($urandom_range(0, 4) == 0);
        phases++;
        for (int k = 0; k < npix; k++) begin
            case ($urandom_range(0, 7))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            send_pixel(word);
            if ($urandom_range(0, 19) == 0) begin
                // Let the output side empty completely before the next beat.
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
        end
        drain();
    endtask

    task automatic run_directed();
        // Reset registers give a one-pixel thumbnail per one-pixel frame.
        send_pixel('0);
        send_pixel('1);
        drain();
        // Zero width reads as one, an oversized height as the maximum; the width rounds to zero.
        run_phase(t_dim'(0), t_dim'(8191), t_dim'(2), 1'b0, 3);
        // An oversized target saturates to the longer side, so every pixel is kept.
        run_phase(t_dim'(4), t_dim'(2), t_dim'(8191), 1'b0, 8);
        // Pixels after the last kept one are swallowed; the next frame begins afterwards.
        run_phase(t_dim'(3), t_dim'(2), t_dim'(2), 1'b0, 8);
        // Writes in mid-frame, including the spare index, restart the frame.
        run_phase(t_dim'(3), t_dim'(2), t_dim'(2), 1'b1, 2);
    endtask

    task automatic run_random();
        int sent;
        int kind;
        int frame;
        int npix;
        t_dim sw, sh, ts;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                sw = t_dim'($urandom_range(1, 10));
                sh = t_dim'($urandom_range(1, 10));
                if ($urandom_range(0, 7) == 0) sw = '0;
                if ($urandom_range(0, 7) == 0) sh = '0;
                case ($urandom_range(0, 3))
                    0:       ts = t_dim'($urandom_range(0, 3));
                    1:       ts = t_dim'($urandom_range(0, 12));
                    2:       ts = t_dim'($urandom);
                    default: ts = t_dim'(MAX_DIM);
                endcase
                frame = thumb_scoreboard::clamp_dim(sw) * thumb_scoreboard::clamp_dim(sh);
                npix = frame * $urandom_range(1, 3);
                // Now and then a frame is cut short by the next settings.
                if ($urandom_range(0, 3) == 0) npix += $urandom_range(1, frame);
            end else begin
                ts = ($urandom_range(0, 1) == 0) ? t_dim'(MAX_DIM) : t_dim'($urandom);
                if (kind == 8) begin
                    sw = ($urandom_range(0, 1) == 0) ? t_dim'(MAX_DIM)
                                                     : t_dim'($urandom_range(3900, 8191));
                    sh = t_dim'($urandom_range(1, 3));
                end else begin
                    sw = t_dim'($urandom_range(1, 3));
                    sh = ($urandom_range(0, 1) == 0) ? t_dim'(MAX_DIM)
                                                     : t_dim'($urandom_range(3900, 8191));
                end
                npix = $urandom_range(1, 40);
            end
            run_phase(sw, sh, ts, $urandom_range(0, 7) == 0, npix);
            sent += npix;
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_SOURCE_WIDTH;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_pixel_word <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        run_directed();
        run_random();

        drain();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Covered %0d pixel beats over %0d register settings,", beats_in, phases);
        $display("with %0d thumbnail pixels checked and %0d thumbnails completed.",
                 sb.checked, sb.frames_done);
        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
